@@ design/dxte_pkg.sv @@
// Package for the XML text run extractor: shared constants, types and
// pattern lookup functions. No dependencies.
package dxte_pkg;

    // Sizes.
    localparam int HoldDepth = 6;
    localparam int MaxOut    = 8;
    localparam int QDepthDef = 16;
    localparam int OutCntW   = $clog2(MaxOut + 1);
    localparam int HoldCntW  = $clog2(HoldDepth + 1);
    localparam int HoldIdxW  = $clog2(HoldDepth);
    localparam int OpenLen   = 4;
    localparam int CloseLen  = 6;
    localparam int EntCount  = 5;

    // Scanner phase codes.
    localparam logic [1:0] PhSeek = 2'd0;
    localparam logic [1:0] PhAttr = 2'd1;
    localparam logic [1:0] PhRun  = 2'd2;

    // Character codes.
    localparam logic [7:0] ChLt    = 8'h3C;
    localparam logic [7:0] ChGt    = 8'h3E;
    localparam logic [7:0] ChAmp   = 8'h26;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChQuot  = 8'h22;
    localparam logic [7:0] ChApos  = 8'h27;

    // Entity indexes.
    localparam logic [2:0] EntAmp  = 3'd0;
    localparam logic [2:0] EntLt   = 3'd1;
    localparam logic [2:0] EntGt   = 3'd2;
    localparam logic [2:0] EntQuot = 3'd3;
    localparam logic [2:0] EntApos = 3'd4;

    // One result item.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       run_end;
        logic       run_cancel;
    } t_item;

    typedef t_item [MaxOut-1:0] t_items;

    // Results caused by one accepted byte, handed from scanner to queue.
    typedef struct packed {
        logic [OutCntW-1:0] count;
        t_items             items;
    } t_burst;

    typedef logic [HoldDepth-1:0][7:0] t_held;

    typedef struct packed {
        logic       complete;
        logic       prefix;
        logic [7:0] value;
    } t_ent_res;

    // Character of "<w:t" at a position.
    function automatic logic [7:0] open_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = "<";
            2'd1:    c = "w";
            2'd2:    c = ":";
            default: c = "t";
        endcase
        return c;
    endfunction

    // Character of "</w:t>" at a position.
    function automatic logic [7:0] close_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "<";
            3'd1:    c = "/";
            3'd2:    c = "w";
            3'd3:    c = ":";
            3'd4:    c = "t";
            default: c = ">";
        endcase
        return c;
    endfunction

    // Entity text, padded with spaces to six characters.
    function automatic logic [47:0] ent_str(input logic [2:0] k);
        logic [47:0] s;
        unique case (k)
            EntAmp:  s = "&amp; ";
            EntLt:   s = "&lt;  ";
            EntGt:   s = "&gt;  ";
            EntQuot: s = "&quot;";
            default: s = "&apos;";
        endcase
        return s;
    endfunction

    function automatic int ent_len(input logic [2:0] k);
        int n;
        unique case (k)
            EntAmp:  n = 5;
            EntLt:   n = 4;
            EntGt:   n = 4;
            EntQuot: n = 6;
            default: n = 6;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] ent_value(input logic [2:0] k);
        logic [7:0] v;
        unique case (k)
            EntAmp:  v = ChAmp;
            EntLt:   v = ChLt;
            EntGt:   v = ChGt;
            EntQuot: v = ChQuot;
            default: v = ChApos;
        endcase
        return v;
    endfunction

    // Match the held prefix plus a new byte against all entities.
    function automatic t_ent_res ent_match(input t_held held, input logic [2:0] n,
                                           input logic [7:0] b);
        t_ent_res    res;
        logic [47:0] s;
        logic [7:0]  c;
        logic        ok;
        int          len;
        res = '0;
        for (int k = 0; k < EntCount; k++) begin
            s   = ent_str(3'(k));
            len = ent_len(3'(k));
            if (len >= int'(n) + 1) begin
                ok = 1'b1;
                for (int j = 0; j < HoldDepth; j++) begin
                    if (j <= int'(n)) begin
                        c = (j == int'(n)) ? b : held[j];
                        if (c != s[8*(5-j) +: 8]) begin
                            ok = 1'b0;
                        end
                    end
                end
                if (ok) begin
                    if (len == int'(n) + 1) begin
                        res.complete = 1'b1;
                        res.value    = ent_value(3'(k));
                    end else begin
                        res.prefix = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

endpackage

@@ design/dxte_front.sv @@
// Front part of the extractor: tag matching, entity decoding and run bookkeeping.
// Produces the burst of result items for each accepted byte. Depends on dxte_pkg.
module dxte_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_xml_byte,
    input  logic            i_doc_end,
    output dxte_pkg::t_burst o_burst
);
    import dxte_pkg::*;

    logic [1:0]          r_phase, n_phase;
    logic [2:0]          r_open_len, n_open_len;
    logic                r_prev_slash, n_prev_slash;
    t_held               r_held, n_held;
    logic [HoldCntW-1:0] r_held_n, n_held_n;
    logic [7:0]          r_pend_byte, n_pend_byte;
    logic                r_pend_valid, n_pend_valid;

    logic [HoldCntW-1:0] flush_n;
    logic                one_valid;
    logic [7:0]          one_byte;
    logic                do_fresh;
    logic                close_done;
    t_ent_res            ent;
    logic [7:0]          ch [MaxOut-1];
    logic [2:0]          chain_n;
    logic [OutCntW-1:0]  cnt;
    t_items              items;
    int                  pos;

    always_comb begin
        n_phase      = r_phase;
        n_open_len   = r_open_len;
        n_prev_slash = r_prev_slash;
        n_held       = r_held;
        n_held_n     = r_held_n;
        n_pend_byte  = r_pend_byte;
        n_pend_valid = r_pend_valid;
        flush_n      = '0;
        one_valid    = 1'b0;
        one_byte     = i_xml_byte;
        do_fresh     = 1'b0;
        close_done   = 1'b0;
        ent          = ent_match(r_held, r_held_n, i_xml_byte);
        items        = '0;
        cnt          = '0;

        // Classify the byte according to the scanner phase.
        unique case (r_phase)
            PhRun: begin
                if (r_held_n == '0 || int'(r_held_n) >= HoldDepth) begin
                    do_fresh = 1'b1;
                end else if (r_held[0] == ChLt) begin
                    if (i_xml_byte == close_char(r_held_n)) begin
                        if (int'(r_held_n) == CloseLen - 1) begin
                            close_done   = 1'b1;
                            n_held_n     = '0;
                            n_phase      = PhSeek;
                            n_open_len   = '0;
                            n_prev_slash = 1'b0;
                            n_pend_valid = 1'b0;
                            n_pend_byte  = '0;
                        end else begin
                            n_held[HoldIdxW'(r_held_n)] = i_xml_byte;
                            n_held_n = r_held_n + 1'b1;
                        end
                    end else begin
                        flush_n  = r_held_n;
                        do_fresh = 1'b1;
                    end
                end else if (ent.complete) begin
                    n_held_n  = '0;
                    one_valid = 1'b1;
                    one_byte  = ent.value;
                end else if (ent.prefix) begin
                    n_held[HoldIdxW'(r_held_n)] = i_xml_byte;
                    n_held_n = r_held_n + 1'b1;
                end else begin
                    flush_n  = r_held_n;
                    do_fresh = 1'b1;
                end
            end
            PhAttr: begin
                if (i_xml_byte == ChGt) begin
                    n_phase      = r_prev_slash ? PhSeek : PhRun;
                    n_prev_slash = 1'b0;
                    n_open_len   = '0;
                end else begin
                    n_prev_slash = (i_xml_byte == ChSlash);
                end
            end
            default: begin
                if (int'(r_open_len) >= OpenLen) begin
                    n_open_len = (i_xml_byte == ChLt) ? 3'd1 : 3'd0;
                    if (i_xml_byte == ChGt) begin
                        n_phase    = PhRun;
                        n_open_len = '0;
                    end else if (i_xml_byte == ChSpace || i_xml_byte == ChSlash) begin
                        n_phase      = PhAttr;
                        n_open_len   = '0;
                        n_prev_slash = (i_xml_byte == ChSlash);
                    end
                end else if (i_xml_byte == open_char(r_open_len[1:0])) begin
                    n_open_len = r_open_len + 3'd1;
                end else begin
                    n_open_len = (i_xml_byte == ChLt) ? 3'd1 : 3'd0;
                end
            end
        endcase

        // A fresh byte either starts a new held prefix or is plain text.
        if (do_fresh) begin
            if (i_xml_byte == ChLt || i_xml_byte == ChAmp) begin
                n_held[0] = i_xml_byte;
                n_held_n  = HoldCntW'(1);
            end else begin
                n_held_n  = '0;
                one_valid = 1'b1;
            end
        end

        // Chain of text bytes: pending byte, flushed held bytes, then one new byte.
        for (int j = 0; j < MaxOut - 1; j++) begin
            ch[j] = '0;
            pos   = r_pend_valid ? j - 1 : j;
            if (r_pend_valid && j == 0) begin
                ch[j] = r_pend_byte;
            end else if (pos < int'(flush_n)) begin
                ch[j] = r_held[HoldIdxW'(pos)];
            end else if (pos == int'(flush_n) && one_valid) begin
                ch[j] = one_byte;
            end
        end
        chain_n = 3'(r_pend_valid) + 3'(flush_n) + 3'(one_valid);

        // All but the last chain byte leave now; the last one stays pending.
        if (close_done) begin
            items[0] = '{text_byte: r_pend_byte, run_end: 1'b1, run_cancel: 1'b0};
            cnt      = OutCntW'(r_pend_valid);
        end else begin
            for (int j = 0; j < MaxOut - 1; j++) begin
                items[j] = '{text_byte: ch[j], run_end: 1'b0, run_cancel: 1'b0};
            end
            if (chain_n != 3'd0) begin
                cnt          = OutCntW'(chain_n - 3'd1);
                n_pend_valid = 1'b1;
                n_pend_byte  = ch[chain_n - 3'd1];
            end
        end

        // Document end: cancel an open run, then return to the reset state.
        if (i_doc_end) begin
            if (n_phase == PhRun) begin
                items[cnt[2:0]] = '{text_byte: 8'd0, run_end: 1'b0, run_cancel: 1'b1};
                cnt = cnt + 1'b1;
            end
            n_phase      = PhSeek;
            n_open_len   = '0;
            n_prev_slash = 1'b0;
            n_held       = '0;
            n_held_n     = '0;
            n_pend_byte  = '0;
            n_pend_valid = 1'b0;
        end

        o_burst.count = i_accept ? cnt : '0;
        o_burst.items = items;
    end

    // State registers, updated on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PhSeek;
            r_open_len   <= '0;
            r_prev_slash <= 1'b0;
            r_held_n     <= '0;
            r_pend_valid <= 1'b0;
            r_held       <= '0;
            r_pend_byte  <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_open_len   <= n_open_len;
            r_prev_slash <= n_prev_slash;
            r_held_n     <= n_held_n;
            r_pend_valid <= n_pend_valid;
            r_held       <= n_held;
            r_pend_byte  <= n_pend_byte;
        end
    end

endmodule

@@ design/dxte_queue.sv @@
// Back part of the extractor: result queue that takes a burst per cycle and
// delivers one result per cycle while i_ready is high. Depends on dxte_pkg.
module dxte_queue #(
    parameter int Depth = dxte_pkg::QDepthDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dxte_pkg::t_burst i_burst,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output dxte_pkg::t_item  o_item
);
    import dxte_pkg::*;

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = PtrW + 1;

    t_item            r_mem [Depth];
    logic [PtrW-1:0]  r_wptr, n_wptr;
    logic [PtrW-1:0]  r_rptr, n_rptr;
    logic [CntW-1:0]  r_count, n_count;
    logic             pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign o_space = (int'(r_count) <= Depth - MaxOut);

    // Pointer and fill count arithmetic.
    always_comb begin
        n_wptr  = r_wptr + PtrW'(i_burst.count);
        n_rptr  = r_rptr + PtrW'(pop);
        n_count = r_count + CntW'(i_burst.count) - CntW'(pop);
    end

    // Store the burst at consecutive slots.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MaxOut; i++) begin
            if (i < int'(i_burst.count)) begin
                r_mem[r_wptr + PtrW'(i)] <= i_burst.items[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

@@ design/doc_xml_text_run_extractor_top.sv @@
// XML text run extractor: takes one document byte per cycle and returns decoded run bytes.
// Throughput: one byte per cycle while the result queue has room for a full burst of
// eight results; a byte may release up to seven results, drained one per cycle
// while the output is ready. Results are written into the queue when the releasing
// byte is accepted; each text byte is released when the following byte is accepted.
// Reset: synchronous, active low; clears the scanner and empties the queue at once.
module doc_xml_text_run_extractor_top #(
    parameter int QueueDepth = dxte_pkg::QDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_xml_byte,
    input  logic       i_doc_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_text_byte,
    output logic       o_run_end,
    output logic       o_run_cancel
);
    import dxte_pkg::*;

    t_burst burst;
    t_item  item;
    logic   space;
    logic   accept;

    // Input transaction completes when the queue can absorb a full burst.
    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    dxte_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_xml_byte (i_xml_byte),
        .i_doc_end  (i_doc_end),
        .o_burst    (burst)
    );

    dxte_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_burst (burst),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (item)
    );

    assign o_text_byte  = item.text_byte;
    assign o_run_end    = item.run_end;
    assign o_run_cancel = item.run_cancel;

endmodule
